// File: src/exact_fit_heap_allocator_defines.svh
// Assertion macros used by the heap allocator datapath (efha_datapath).
// Define ASSERT_OFF to compile every assertion away.
`ifndef EXACT_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define EXACT_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define EFHA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define EFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define EFHA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define EFHA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/efha_pkg.sv
// Types and constants of the exact-fit heap allocator.
// Used by efha_ctrl, efha_datapath and exact_fit_heap_allocator; depends on nothing.
package efha_pkg;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_EXHAUSTED  = 2'd1;
   localparam status_type STATUS_TABLE_FULL = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   // Sizes are rounded up to a multiple of four bytes.
   localparam logic [32:0] ROUND_ADD  = 33'd3;
   localparam logic [32:0] ROUND_MASK = ~33'd3;

   typedef struct packed {
      logic load_req;
      logic push_free;
      logic fail;
      logic scan_start;
      logic scan_step;
      logic compact_start;
      logic compact_step;
      logic count_dec;
      logic top_calc;
      logic align_calc;
      logic newtop_calc;
      logic bump_commit;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic kind_free;
      logic round_over;
      logic count_zero;
      logic hit;
      logic scan_end;
      logic compact_end;
      logic rsp_free;
   } sts_type;

endpackage

// File: src/efha_ctrl.sv
// Sequencing state machine of the heap allocator.
// Depends on efha_pkg; drives efha_datapath through cmd_type, reads sts_type.
module efha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  efha_pkg::sts_type sts,
   output efha_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_SCAN    = 4'd2;
   localparam logic [3:0] S_COMPACT = 4'd3;
   localparam logic [3:0] S_TOP     = 4'd4;
   localparam logic [3:0] S_ALIGN   = 4'd5;
   localparam logic [3:0] S_NEWTOP  = 4'd6;
   localparam logic [3:0] S_CHECK   = 4'd7;
   localparam logic [3:0] S_DONE    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.kind_free) begin
               cmd.push_free = 1'b1;
               state_in      = S_DONE;
            end else if (sts.round_over) begin
               cmd.fail = 1'b1;
               state_in = S_DONE;
            end else if (sts.count_zero) begin
               state_in = S_TOP;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               cmd.compact_start = 1'b1;
               state_in          = S_COMPACT;
            end else if (sts.scan_end) begin
               state_in = S_TOP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_COMPACT: begin
            if (sts.compact_end) begin
               cmd.count_dec = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.compact_step = 1'b1;
            end
         end
         S_TOP: begin
            cmd.top_calc = 1'b1;
            state_in     = S_ALIGN;
         end
         S_ALIGN: begin
            cmd.align_calc = 1'b1;
            state_in       = S_NEWTOP;
         end
         S_NEWTOP: begin
            cmd.newtop_calc = 1'b1;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            cmd.bump_commit = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/efha_datapath.sv
// Datapath of the heap allocator: registers, free table memory, heap top arithmetic.
// Depends on efha_pkg and exact_fit_heap_allocator_defines.svh; driven by efha_ctrl.
`include "exact_fit_heap_allocator_defines.svh"
module efha_datapath #(
   parameter int FREE_ENTRIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  efha_pkg::cmd_type       cmd,
   output efha_pkg::sts_type       sts,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [31:0]             csr_wdata,
   input  logic                    req_kind,
   input  logic [31:0]             req_size,
   input  logic [4:0]              req_align_log2,
   input  logic [31:0]             req_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [31:0]             rsp_block_address,
   output efha_pkg::status_type    rsp_status
);

   localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(FREE_ENTRIES);
   localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

   // Configuration and heap state.
   logic [31:0]      base_ff, limit_ff, used_ff, used_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Latched request.
   logic             kind_ff;
   logic [32:0]      rounded_ff;
   logic [4:0]       alog_ff;
   logic [31:0]      addr_ff;

   // Free table.
   logic [31:0]      mem_start  [FREE_ENTRIES];
   logic [31:0]      mem_length [FREE_ENTRIES];
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_start, wr_length;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_start_ff, rd_length_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_valid_ff, rd_valid_in;

   // Walk pointer shared by the search and the compaction.
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             live_ff, live_in;

   // Heap top pipeline.
   logic [32:0]      top_ff;
   logic [33:0]      aligned_ff;
   logic [34:0]      new_top_ff;
   logic [31:0]      gap_raw_ff;
   logic             gap_nz_ff;
   logic [31:0]      amask;
   logic [33:0]      aligned_sum;
   logic [31:0]      gap_len;
   logic             over;

   // Result staging and output register.
   logic [31:0]          res_addr_ff, res_addr_in;
   efha_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_addr_ff;
   efha_pkg::status_type rsp_status_ff;

   logic             not_full;
   logic [CNT_W-1:0] cnt_m1, ptr_p1, idx_p1;

   assign amask       = ~(32'hFFFF_FFFF << alog_ff);
   assign aligned_sum = {1'b0, top_ff} + {2'b00, amask};
   assign gap_len     = 32'((33'(gap_raw_ff) + efha_pkg::ROUND_ADD) & efha_pkg::ROUND_MASK);
   assign over        = new_top_ff > {3'b000, limit_ff};
   assign not_full    = count_ff < FULL;
   assign cnt_m1      = count_ff - ONE;
   assign ptr_p1      = CNT_W'(ptr_ff) + ONE;
   assign idx_p1      = CNT_W'(rd_idx_ff) + ONE;

   always_comb begin
      sts.kind_free   = (kind_ff == efha_pkg::KIND_FREE);
      sts.round_over  = rounded_ff[32];
      sts.count_zero  = (count_ff == '0);
      sts.hit         = rd_valid_ff && ({1'b0, rd_length_ff} == rounded_ff)
                        && ((rd_start_ff & amask) == 32'd0);
      sts.scan_end    = !live_ff && !rd_valid_ff;
      sts.compact_end = !live_ff && !rd_valid_ff;
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Table write port, read port, walk pointer and state updates.
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_start      = addr_ff;
      wr_length     = rounded_ff[31:0];
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      rd_valid_in   = rd_valid_ff;
      ptr_in        = ptr_ff;
      live_in       = live_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;

      if (cmd.push_free) begin
         res_addr_in = 32'd0;
         if (not_full) begin
            wr_en         = 1'b1;
            count_in      = count_ff + ONE;
            res_status_in = efha_pkg::STATUS_OK;
         end else begin
            res_status_in = efha_pkg::STATUS_TABLE_FULL;
         end
      end

      if (cmd.fail) begin
         res_addr_in   = 32'd0;
         res_status_in = efha_pkg::STATUS_EXHAUSTED;
      end

      if (cmd.scan_start) begin
         ptr_in      = cnt_m1[IDX_W-1:0];
         live_in     = 1'b1;
         rd_valid_in = 1'b0;
      end

      if (cmd.scan_step) begin
         rd_en       = live_ff;
         rd_valid_in = live_ff;
         if (ptr_ff == '0) begin
            live_in = 1'b0;
         end else begin
            ptr_in = ptr_ff - IDX_W'(1);
         end
      end

      if (cmd.compact_start) begin
         res_addr_in   = rd_start_ff;
         res_status_in = efha_pkg::STATUS_OK;
         ptr_in        = idx_p1[IDX_W-1:0];
         live_in       = idx_p1 < count_ff;
         rd_valid_in   = 1'b0;
      end

      if (cmd.compact_step) begin
         // Entry read last cycle moves down by one place.
         if (rd_valid_ff) begin
            wr_en     = 1'b1;
            wr_addr   = rd_idx_ff - IDX_W'(1);
            wr_start  = rd_start_ff;
            wr_length = rd_length_ff;
         end
         rd_en       = live_ff;
         rd_valid_in = live_ff;
         if (live_ff) begin
            ptr_in  = ptr_p1[IDX_W-1:0];
            live_in = ptr_p1 < count_ff;
         end
      end

      if (cmd.count_dec) begin
         count_in = cnt_m1;
      end

      if (cmd.bump_commit) begin
         if (over) begin
            res_addr_in   = 32'd0;
            res_status_in = efha_pkg::STATUS_EXHAUSTED;
         end else begin
            res_addr_in   = aligned_ff[31:0];
            res_status_in = efha_pkg::STATUS_OK;
            used_in       = 32'(new_top_ff - {3'b000, base_ff});
            if (gap_nz_ff && not_full) begin
               wr_en     = 1'b1;
               wr_start  = top_ff[31:0];
               wr_length = gap_len;
               count_in  = count_ff + ONE;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Free table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr]  <= wr_start;
         mem_length[wr_addr] <= wr_length;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_start_ff  <= mem_start[rd_addr];
         rd_length_ff <= mem_length[rd_addr];
         rd_idx_ff    <= rd_addr;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 32'd0;
         limit_ff     <= 32'd0;
         used_ff      <= 32'd0;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               efha_pkg::REG_HEAP_BASE:  base_ff  <= csr_wdata;
               efha_pkg::REG_HEAP_LIMIT: limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         used_ff      <= used_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff    <= req_kind;
         rounded_ff <= ({1'b0, req_size} + efha_pkg::ROUND_ADD) & efha_pkg::ROUND_MASK;
         alog_ff    <= req_align_log2;
         addr_ff    <= req_address;
      end
      if (cmd.top_calc) begin
         top_ff <= {1'b0, base_ff} + {1'b0, used_ff};
      end
      if (cmd.align_calc) begin
         aligned_ff <= aligned_sum & ~{2'b00, amask};
      end
      if (cmd.newtop_calc) begin
         new_top_ff <= {1'b0, aligned_ff} + {2'b00, rounded_ff};
         gap_raw_ff <= aligned_ff[31:0] - top_ff[31:0];
         gap_nz_ff  <= aligned_ff != {1'b0, top_ff};
      end
      ptr_ff        <= ptr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (cmd.out_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   `EFHA_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= FULL)
   `EFHA_ASSERT_NEXT(a_fail_keeps_top, clock, reset, cmd.bump_commit && over, $stable(used_ff))
   `EFHA_ASSERT_IMPLIES(a_shift_index, clock, reset, cmd.compact_step && rd_valid_ff,
                        rd_idx_ff != '0)

endmodule

// File: src/exact_fit_heap_allocator.sv
// Top level of the exact-fit heap allocator with a bump pointer.
// Depends on efha_pkg, efha_ctrl and efha_datapath.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  tuser kind, tdata size, align_log2, address
//   rsp_     out        rsp_tvalid/rsp_tready  tdata block_address, status
//   csr_     in         csr_we (no wait)       csr_index selects heap_base or heap_limit
//
// A free transaction pushes its block onto the free table, or reports the table full. An
// allocation that hits the free table entry at index m of n live entries takes it out: the
// search reads one entry per cycle through the registered table read port, and compaction
// moves one entry per cycle through the same port. A miss runs the search, skipped with an
// empty table, and then four heap top steps.
// Reset is synchronous and clears base, limit, used size (heap top), entry count and valid
// flags; table contents need no clearing because only entries below the count are read.
// One request is in flight at a time; its result waits in the output register, so a
// stalled rsp_tready holds the next request in its last step and blocks the one after it.
module exact_fit_heap_allocator #(
   parameter int FREE_ENTRIES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: size [31:0], align_log2 [36:32], address [68:37], zero fill.
   input  logic [efha_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: kind.
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: block_address [31:0], status [33:32], zero fill.
   output logic [efha_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [31:0]                     csr_wdata
);

   efha_pkg::cmd_type    cmd;
   efha_pkg::sts_type    sts;
   logic [31:0]          block_address;
   efha_pkg::status_type status;

   // The controller owns the sequence of steps; it accepts a request only when idle.
   efha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the free table, the heap top arithmetic and the output register.
   efha_datapath #(
      .FREE_ENTRIES (FREE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_kind          (req_tuser),
      .req_size          (req_tdata[31:0]),
      .req_align_log2    (req_tdata[36:32]),
      .req_address       (req_tdata[68:37]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_block_address (block_address),
      .rsp_status        (status)
   );

   // Result packing: address in the low word, status above it, zero fill to whole bytes.
   assign rsp_tdata = {6'b000000, status, block_address};

endmodule
